// ===== hdl/gbc_pkg.sv =====
// Shared types, codes and the sensitivity table for the gyro bias calibrate
// and convert block. No dependencies.
package gbc_pkg;

   // Operation classes decided at the front and carried out at the back.
   localparam logic [1:0] OP_ACCUM  = 2'd0;
   localparam logic [1:0] OP_REJECT = 2'd1;
   localparam logic [1:0] OP_MEAS   = 2'd2;

   // Result status codes.
   localparam logic [1:0] ST_ACCUMULATED = 2'd0;
   localparam logic [1:0] ST_CAL_DONE    = 2'd1;
   localparam logic [1:0] ST_REJECTED    = 2'd2;
   localparam logic [1:0] ST_RATE        = 2'd3;

   // Configuration register indexes.
   localparam logic CSR_SAMPLE_COUNT = 1'b0;
   localparam logic CSR_FULL_SCALE   = 1'b1;

   localparam int RAW_W  = 16;
   localparam int SUM_W  = 24;
   localparam int CNT_W  = 16;
   localparam int K_W    = 9;
   localparam int RATE_W = 33;
   localparam int CSR_W  = 16;

   localparam logic signed [RAW_W-1:0] VALID_LIMIT = 16'sd100;

   localparam logic [CNT_W-1:0] SAMPLE_COUNT_RESET = 16'd256;
   localparam logic [1:0]       FULL_SCALE_RESET   = 2'd0;

   typedef struct packed {
      logic [CNT_W-1:0] sample_count;
      logic [1:0]       full_scale;
   } cfg_type;

   typedef struct packed {
      logic [1:0]              op;
      logic signed [RAW_W-1:0] raw_x;
      logic signed [RAW_W-1:0] raw_y;
      logic signed [RAW_W-1:0] raw_z;
   } entry_type;

   // Sensitivity in quarter mdps per LSB; the unused code maps to 2000 dps.
   function automatic logic [K_W-1:0] sens_k(input logic [1:0] fs);
      logic [K_W-1:0] k;
      case (fs)
         2'd0:    k = 9'd35;
         2'd1:    k = 9'd70;
         default: k = 9'd280;
      endcase
      return k;
   endfunction

endpackage

// ===== hdl/gyro_bias_calibrate_convert.sv =====
// Top level of the gyro bias calibrate and convert block: configuration
// registers, front end, queue and back end. Depends on gbc_pkg and the gbc_ modules.
//
// Use:
//  - req_ channel carries one sample word: kind (0 calibration, 1 measurement)
//    and signed raw_x/raw_y/raw_z, taken when req_valid is high and req_stall
//    low. Every word gives exactly one rsp_ word, in order.
//  - rsp_ channel returns status, the three corrected rates (1/1024 mdps,
//    zero unless status is rate result) and the calibrated flag.
//  - csr_ port writes sample_count (index 0) and full_scale (index 1) on any
//    edge with csr_write high; write only while the block is idle.
// Back end (one word at a time):
//  - A measurement holds the back end for the pop with the x multiply, y and
//    z on the shared multiplier and the response load. An accumulated or
//    rejected calibration word holds it for the pop and the response load.
//  - The word that completes a run waits on the bit-serial divider: per axis
//    a start, one bit step per quotient bit (24+BIAS_FRACTION_BITS bits) and
//    a done step, for x, y and z in turn.
// Reset clears the run, biases, calibrated flag and valid state; sample_count
// returns to 256, full_scale to 245 dps. A stalled response word holds; the
// back end finishes its next result, then the queue and front register fill
// and req_stall rises.
module gyro_bias_calibrate_convert import gbc_pkg::*; #(
   parameter int BIAS_FRACTION_BITS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write,
   input  logic                     csr_index,
   input  logic [CSR_W-1:0]         csr_wdata,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_kind,
   input  logic signed [RAW_W-1:0]  req_raw_x,
   input  logic signed [RAW_W-1:0]  req_raw_y,
   input  logic signed [RAW_W-1:0]  req_raw_z,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_status,
   output logic signed [RATE_W-1:0] rsp_rate_x,
   output logic signed [RATE_W-1:0] rsp_rate_y,
   output logic signed [RATE_W-1:0] rsp_rate_z,
   output logic                     rsp_is_calibrated
);

   cfg_type   cfg_ff, cfg_in;
   logic      push;
   entry_type push_entry;
   logic      q_full;
   logic      q_pop;
   logic      q_not_empty;
   entry_type q_head;

   // Register writes: take the low bits each register needs.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_SAMPLE_COUNT: cfg_in.sample_count = csr_wdata[CNT_W-1:0];
            CSR_FULL_SCALE:   cfg_in.full_scale   = csr_wdata[1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_count <= SAMPLE_COUNT_RESET;
         cfg_ff.full_scale   <= FULL_SCALE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Classify and hold one word ahead of the queue.
   gbc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_kind   (req_kind),
      .req_raw_x  (req_raw_x),
      .req_raw_y  (req_raw_y),
      .req_raw_z  (req_raw_z),
      .push       (push),
      .push_entry (push_entry),
      .queue_full (q_full)
   );

   gbc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .head       (q_head)
   );

   // Carry out the word and drive the response register.
   gbc_back #(
      .BIAS_FRACTION_BITS (BIAS_FRACTION_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .q_not_empty       (q_not_empty),
      .q_head            (q_head),
      .pop               (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_rate_x        (rsp_rate_x),
      .rsp_rate_y        (rsp_rate_y),
      .rsp_rate_z        (rsp_rate_z),
      .rsp_is_calibrated (rsp_is_calibrated)
   );

endmodule

// ===== hdl/gbc_front.sv =====
// Front end: takes request words, classifies them and holds one word for
// the queue. Depends on gbc_pkg.
module gbc_front import gbc_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_kind,
   input  logic signed [RAW_W-1:0] req_raw_x,
   input  logic signed [RAW_W-1:0] req_raw_y,
   input  logic signed [RAW_W-1:0] req_raw_z,
   output logic                    push,
   output entry_type               push_entry,
   input  logic                    queue_full
);

   logic      valid_ff, valid_in;
   entry_type entry_ff, entry_in;
   logic      accept;
   logic      out_of_range;

   function automatic logic too_large(input logic signed [RAW_W-1:0] v);
      return (v > VALID_LIMIT) || (v < -VALID_LIMIT);
   endfunction

   assign req_stall = valid_ff && queue_full;
   assign accept    = req_valid && !req_stall;
   assign push      = valid_ff && !queue_full;
   assign push_entry = entry_ff;

   assign out_of_range = too_large(req_raw_x) || too_large(req_raw_y) ||
                         too_large(req_raw_z) || (cfg.sample_count == '0);

   always_comb begin
      valid_in = valid_ff && queue_full;
      entry_in = entry_ff;
      if (accept) begin
         valid_in       = 1'b1;
         entry_in.raw_x = req_raw_x;
         entry_in.raw_y = req_raw_y;
         entry_in.raw_z = req_raw_z;
         if (req_kind) begin
            entry_in.op = OP_MEAS;
         end else if (out_of_range) begin
            entry_in.op = OP_REJECT;
         end else begin
            entry_in.op = OP_ACCUM;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
   end

endmodule

// ===== hdl/gbc_queue.sv =====
// Two-word queue between front and back, held in flip-flops.
// Depends on gbc_pkg.
module gbc_queue import gbc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      not_empty,
   output entry_type head
);

   entry_type  slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== hdl/gbc_div.sv =====
// Restoring divider, one quotient bit a cycle, sign applied at the end so
// the quotient truncates toward zero. No package dependency.
module gbc_div #(
   parameter int NUM_W = 32,
   parameter int DEN_W = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num_mag,
   input  logic             num_neg,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CW = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             neg_ff, neg_in;
   logic [DEN_W:0]   trial;
   logic             fits;

   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign fits  = (trial >= {1'b0, den_ff});
   assign done  = done_ff;
   assign quot  = neg_ff ? (~quo_ff + NUM_W'(1)) : quo_ff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = num_mag;
         rem_in  = '0;
         den_in  = den;
         neg_in  = num_neg;
         cnt_in  = CW'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift one dividend bit in, subtract where the divisor fits
         rem_in = fits ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

endmodule

// ===== hdl/gbc_back.sv =====
// Back end: runs calibration sums, bias division and rate conversion, and
// owns the response register. Depends on gbc_pkg and gbc_div.
module gbc_back import gbc_pkg::*; #(
   parameter int BIAS_FRACTION_BITS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cfg_type                  cfg,
   input  logic                     q_not_empty,
   input  entry_type                q_head,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_status,
   output logic signed [RATE_W-1:0] rsp_rate_x,
   output logic signed [RATE_W-1:0] rsp_rate_y,
   output logic signed [RATE_W-1:0] rsp_rate_z,
   output logic                     rsp_is_calibrated
);

   localparam int F      = BIAS_FRACTION_BITS;
   localparam int BIAS_W = 8 + F;
   localparam int DIFF_W = RAW_W + 1 + F;
   localparam int PROD_W = DIFF_W + K_W + 1;
   localparam int SC_W   = PROD_W + 8;
   localparam int NUM_W  = SUM_W + F;
   localparam int LSH    = (F <= 8) ? (8 - F) : 0;
   localparam int RSH    = (F > 8) ? (F - 8) : 0;
   localparam logic [SC_W-1:0] RND = (SC_W'(1) << RSH) - SC_W'(1);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_MUL     = 3'd1;
   localparam logic [2:0] S_DIV_GO  = 3'd2;
   localparam logic [2:0] S_DIV_WT  = 3'd3;
   localparam logic [2:0] S_DONE    = 3'd4;

   logic [2:0]              state_ff, state_in;
   logic [1:0]              axis_ff, axis_in;
   logic [1:0]              op_ff, op_in;
   logic [1:0]              status_ff, status_in;
   logic signed [RAW_W-1:0] raw_ff [3];
   logic signed [RAW_W-1:0] raw_in [3];
   logic signed [PROD_W-1:0] prod_ff [3];
   logic signed [PROD_W-1:0] prod_in [3];
   logic signed [SUM_W-1:0] sum_ff [3];
   logic signed [SUM_W-1:0] sum_in [3];
   logic signed [BIAS_W-1:0] bias_ff [3];
   logic signed [BIAS_W-1:0] bias_in [3];
   logic [CNT_W-1:0]        taken_ff, taken_in;
   logic                    cal_ff, cal_in;

   logic                     out_valid_ff, out_valid_in;
   logic [1:0]               out_status_ff;
   logic signed [RATE_W-1:0] out_rate_ff [3];
   logic                     out_cal_ff;
   logic                     out_load;

   logic signed [RAW_W-1:0]  head_raw [3];
   logic signed [SUM_W-1:0]  sum_next [3];
   logic [CNT_W-1:0]         n_next;
   logic signed [RAW_W-1:0]  mul_raw;
   logic signed [BIAS_W-1:0] mul_bias;
   logic signed [DIFF_W-1:0] diff;
   logic signed [PROD_W-1:0] prod;
   logic [K_W-1:0]           k_sel;

   logic                     div_start;
   logic [SUM_W-1:0]         div_mag;
   logic                     div_neg;
   logic                     div_done;
   logic [NUM_W-1:0]         div_quot;

   // Scale the product to 1/1024 mdps; right shifts truncate toward zero.
   function automatic logic [RATE_W-1:0] scale_rate(input logic signed [PROD_W-1:0] p);
      logic signed [SC_W-1:0] ext;
      logic signed [SC_W-1:0] res;
      ext = SC_W'(p);
      if (F <= 8) begin
         res = ext <<< LSH;
      end else begin
         res = (ext + $signed(ext[SC_W-1] ? RND : '0)) >>> RSH;
      end
      return res[RATE_W-1:0];
   endfunction

   gbc_div #(
      .NUM_W (NUM_W),
      .DEN_W (CNT_W)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .num_mag ({div_mag, F'(0)}),
      .num_neg (div_neg),
      .den     (cfg.sample_count >= n_next ? cfg.sample_count : n_next),
      .done    (div_done),
      .quot    (div_quot)
   );

   assign head_raw[0] = q_head.raw_x;
   assign head_raw[1] = q_head.raw_y;
   assign head_raw[2] = q_head.raw_z;

   // Sample count of the finished run: taken_ff holds it while dividing.
   assign n_next = taken_ff + CNT_W'(1);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum_next[i] = sum_ff[i] + SUM_W'(head_raw[i]);
      end
   end

   assign div_mag = sum_ff[axis_ff][SUM_W-1] ? SUM_W'(-sum_ff[axis_ff])
                                             : SUM_W'(sum_ff[axis_ff]);
   assign div_neg = sum_ff[axis_ff][SUM_W-1];

   // Shared multiplier: axis 0 comes straight from the queue head.
   assign k_sel    = sens_k(cfg.full_scale);
   assign mul_raw  = (state_ff == S_IDLE) ? head_raw[0] : raw_ff[axis_ff];
   assign mul_bias = (state_ff == S_IDLE) ? bias_ff[0] : bias_ff[axis_ff];
   assign diff     = $signed({mul_raw[RAW_W-1], mul_raw, F'(0)}) - DIFF_W'(mul_bias);
   assign prod     = diff * $signed({1'b0, k_sel});

   assign pop      = (state_ff == S_IDLE) && q_not_empty;
   assign out_load = (state_ff == S_DONE) && (!out_valid_ff || !rsp_stall);

   always_comb begin
      state_in  = state_ff;
      axis_in   = axis_ff;
      op_in     = op_ff;
      status_in = status_ff;
      raw_in    = raw_ff;
      prod_in   = prod_ff;
      sum_in    = sum_ff;
      bias_in   = bias_ff;
      taken_in  = taken_ff;
      cal_in    = cal_ff;
      div_start = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (q_not_empty) begin
               op_in  = q_head.op;
               raw_in = head_raw;
               case (q_head.op)
                  OP_MEAS: begin
                     prod_in[0] = prod;
                     axis_in    = 2'd1;
                     status_in  = ST_RATE;
                     state_in   = S_MUL;
                  end
                  OP_ACCUM: begin
                     sum_in = sum_next;
                     if (n_next >= cfg.sample_count) begin
                        // run complete: keep the count for the divisor
                        axis_in  = 2'd0;
                        state_in = S_DIV_GO;
                     end else begin
                        taken_in  = n_next;
                        status_in = ST_ACCUMULATED;
                        state_in  = S_DONE;
                     end
                  end
                  default: begin
                     for (int i = 0; i < 3; i++) begin
                        sum_in[i] = '0;
                     end
                     taken_in  = '0;
                     status_in = ST_REJECTED;
                     state_in  = S_DONE;
                  end
               endcase
            end
         end
         S_MUL: begin
            prod_in[axis_ff] = prod;
            axis_in          = axis_ff + 2'd1;
            if (axis_ff == 2'd2) begin
               state_in = S_DONE;
            end
         end
         S_DIV_GO: begin
            div_start = 1'b1;
            state_in  = S_DIV_WT;
         end
         S_DIV_WT: begin
            if (div_done) begin
               bias_in[axis_ff] = div_quot[BIAS_W-1:0];
               if (axis_ff == 2'd2) begin
                  for (int i = 0; i < 3; i++) begin
                     sum_in[i] = '0;
                  end
                  taken_in  = '0;
                  cal_in    = 1'b1;
                  status_in = ST_CAL_DONE;
                  state_in  = S_DONE;
               end else begin
                  axis_in  = axis_ff + 2'd1;
                  state_in = S_DIV_GO;
               end
            end
         end
         S_DONE: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      if (out_load) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         axis_ff      <= 2'd0;
         taken_ff     <= '0;
         cal_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            sum_ff[i]  <= '0;
            bias_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         taken_ff     <= taken_in;
         cal_ff       <= cal_in;
         out_valid_ff <= out_valid_in;
         sum_ff       <= sum_in;
         bias_ff      <= bias_in;
      end
      op_ff     <= op_in;
      status_ff <= status_in;
      raw_ff    <= raw_in;
      prod_ff   <= prod_in;
      if (out_load) begin
         out_status_ff <= status_ff;
         out_cal_ff    <= cal_ff;
         for (int i = 0; i < 3; i++) begin
            out_rate_ff[i] <= (op_ff == OP_MEAS) ? $signed(scale_rate(prod_ff[i])) : '0;
         end
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_rate_x        = out_rate_ff[0];
   assign rsp_rate_y        = out_rate_ff[1];
   assign rsp_rate_z        = out_rate_ff[2];
   assign rsp_is_calibrated = out_cal_ff;

endmodule
